### src/svps_pkg.sv
// Package for the servo pulse stop supervisor: request and register codes,
// reset values, and the item, configuration and result structs.
// No dependencies; every other file in src imports it.
`default_nettype none

package svps_pkg;

  // Request codes carried by in_req_type.
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_UPDATE = 3'd1;
  localparam logic [2:0] REQ_GO     = 3'd2;
  localparam logic [2:0] REQ_STOP   = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_STOP_CURRENT   = 3'd0;
  localparam logic [2:0] CFG_STOP_TIMEOUT   = 3'd1;
  localparam logic [2:0] CFG_LIMIT_ENABLES  = 3'd2;
  localparam logic [2:0] CFG_PULSE_TICKS    = 3'd3;
  localparam logic [2:0] CFG_CURRENT_GAIN   = 3'd4;
  localparam logic [2:0] CFG_CURRENT_OFFSET = 3'd5;
  localparam logic [2:0] CFG_VOLTAGE_GAIN   = 3'd6;
  localparam logic [2:0] CFG_VOLTAGE_OFFSET = 3'd7;

  // Configuration reset values.
  localparam logic [12:0] RST_STOP_CURRENT   = 13'd0;
  localparam logic [14:0] RST_STOP_TIMEOUT   = 15'd0;
  localparam logic [1:0]  RST_LIMIT_ENABLES  = 2'd0;
  localparam logic [15:0] RST_PULSE_TICKS    = 16'd8294;
  localparam logic [15:0] RST_CURRENT_GAIN   = 16'd4336;
  localparam logic [15:0] RST_CURRENT_OFFSET = 16'd1523;
  localparam logic [15:0] RST_VOLTAGE_GAIN   = 16'd11742;
  localparam logic [15:0] RST_VOLTAGE_OFFSET = 16'd15234;

  // Supervision thresholds.
  localparam logic [15:0] LOW_SUPPLY_MV = 16'd4500;
  localparam logic [14:0] INRUSH_TICKS  = 15'd20;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [11:0] current_adc;
    logic [11:0] voltage_adc;
    logic        limit0_hit;
    logic        limit1_hit;
  } item_t;

  typedef struct packed {
    logic [12:0]        stop_current_ma;
    logic [14:0]        stop_timeout;
    logic [1:0]         limit_enables;
    logic [15:0]        pulse_ticks;
    logic [15:0]        current_gain;
    logic signed [15:0] current_offset;
    logic [15:0]        voltage_gain;
    logic signed [15:0] voltage_offset;
  } cfg_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic        pulse_on;
    logic        is_stopped;
    logic        low_supply;
    logic [15:0] current_ma;
    logic [15:0] supply_mv;
    logic [14:0] elapsed_ticks;
  } res_t;

endpackage

`default_nettype wire

### src/svps_scale.sv
// Calibration scaler: (gain * (16 * adc - offset)) >> 16, clamped to 0..65535.
// Depends on nothing but the package import style; used twice by svps_ctrl.
`default_nettype none

module svps_scale
  import svps_pkg::*;
(
  input  wire logic [11:0]        adc,
  input  wire logic [15:0]        gain,
  input  wire logic signed [15:0] offset,
  output logic [15:0]             scaled
);

  logic signed [18:0] diff;
  logic [16:0]        mag;
  logic [32:0]        prod;
  logic [16:0]        quo;

  // Largest difference is 16 * 4095 + 32768, which fits in 17 unsigned bits.
  assign diff = $signed({3'b000, adc, 4'b0000}) - 19'(offset);
  assign mag  = diff[16:0];
  assign prod = 33'(gain) * 33'(mag);
  assign quo  = prod[32:16];

  always_comb begin
    if (diff <= 19'sd0) begin
      scaled = 16'd0;
    end else if (quo[16]) begin
      scaled = 16'hFFFF;
    end else begin
      scaled = quo[15:0];
    end
  end

endmodule

`default_nettype wire

### src/svps_ctrl.sv
// Supervisor state and per-item decision logic: holds the enable, stop, go
// and elapsed state and forms each result. Uses svps_pkg and svps_scale.
`default_nettype none

module svps_ctrl
  import svps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output res_t       res
);

  logic        enabled_r, enabled_nxt;
  logic        stopped_r, stopped_nxt;
  logic        go_pending_r, go_pending_nxt;
  logic        low_supply_r, low_supply_nxt;
  logic [14:0] elapsed_r, elapsed_nxt;
  logic [15:0] current_r, current_nxt;
  logic [15:0] voltage_r, voltage_nxt;

  logic [15:0] cur_scaled;
  logic [15:0] volt_scaled;
  logic        stop_now;
  logic [15:0] width;

  svps_scale u_cur_scale (
    .adc    (item.current_adc),
    .gain   (cfg.current_gain),
    .offset (cfg.current_offset),
    .scaled (cur_scaled)
  );

  svps_scale u_volt_scale (
    .adc    (item.voltage_adc),
    .gain   (cfg.voltage_gain),
    .offset (cfg.voltage_offset),
    .scaled (volt_scaled)
  );

  // The overcurrent check only counts once the inrush window has passed.
  assign stop_now = (cfg.limit_enables[0] && item.limit0_hit) ||
                    (cfg.limit_enables[1] && item.limit1_hit) ||
                    ((cfg.stop_current_ma != 13'd0) && (elapsed_r > INRUSH_TICKS) &&
                     (cur_scaled > {3'b000, cfg.stop_current_ma})) ||
                    ((cfg.stop_timeout != 15'd0) && (elapsed_r >= cfg.stop_timeout));

  always_comb begin
    enabled_nxt    = enabled_r;
    stopped_nxt    = stopped_r;
    go_pending_nxt = go_pending_r;
    low_supply_nxt = low_supply_r;
    elapsed_nxt    = elapsed_r;
    current_nxt    = current_r;
    voltage_nxt    = voltage_r;
    width          = 16'd0;
    unique case (item.req_type)
      REQ_TICK: begin
        if (enabled_r) begin
          elapsed_nxt = elapsed_r + 15'd1;
        end
      end
      REQ_UPDATE: begin
        current_nxt    = cur_scaled;
        voltage_nxt    = volt_scaled;
        low_supply_nxt = volt_scaled < LOW_SUPPLY_MV;
        stopped_nxt    = stop_now;
        if (stop_now) begin
          enabled_nxt = 1'b0;
        end else if (go_pending_r) begin
          enabled_nxt = 1'b1;
        end
        go_pending_nxt = 1'b0;
        width = enabled_nxt ? cfg.pulse_ticks : 16'd0;
      end
      REQ_GO: begin
        enabled_nxt    = 1'b0;
        current_nxt    = 16'd0;
        elapsed_nxt    = 15'd0;
        go_pending_nxt = 1'b1;
      end
      REQ_STOP: begin
        enabled_nxt    = 1'b0;
        go_pending_nxt = 1'b0;
      end
      REQ_CLEAR: begin
        current_nxt = 16'd0;
        elapsed_nxt = 15'd0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.pulse_width   = width;
    res.pulse_on      = enabled_nxt;
    res.is_stopped    = stopped_nxt;
    res.low_supply    = low_supply_nxt;
    res.current_ma    = current_nxt;
    res.supply_mv     = voltage_nxt;
    res.elapsed_ticks = elapsed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      stopped_r    <= 1'b1;
      go_pending_r <= 1'b0;
      low_supply_r <= 1'b0;
      elapsed_r    <= 15'd0;
      current_r    <= 16'd0;
      voltage_r    <= 16'd0;
    end else if (step) begin
      enabled_r    <= enabled_nxt;
      stopped_r    <= stopped_nxt;
      go_pending_r <= go_pending_nxt;
      low_supply_r <= low_supply_nxt;
      elapsed_r    <= elapsed_nxt;
      current_r    <= current_nxt;
      voltage_r    <= voltage_nxt;
    end
  end

  // The pulse is only ever enabled by an update that found no stop condition.
  a_enabled_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    !(enabled_r && stopped_r))
    else $error("pulse enabled while stopped");

  // A pending go always has the pulse disabled until the next update.
  a_pending_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    go_pending_r |-> !enabled_r)
    else $error("go pending while pulse enabled");

  // Ticks taken while disabled must not advance the elapsed count.
  a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (item.req_type == REQ_TICK) && !enabled_r) |=> $stable(elapsed_r))
    else $error("elapsed count moved while disabled");

endmodule

`default_nettype wire

### src/servo_pulse_stop_supervisor_unit.sv
// Top level of the servo pulse stop supervisor: handshake stages, the
// configuration register file and the svps_ctrl decision core.
// Uses svps_pkg, svps_ctrl and, through it, svps_scale.
// - Items arrive on the in_ channel (valid/ready). Each one is a tick, an
//   update carrying ADC readings and limit switch bits, or a go, stop or
//   clear command. Every item yields exactly one result item on out_.
// - An accepted item is captured in an input register. Once the output
//   register is free or being emptied, the decision core scales the readings,
//   evaluates the stop conditions and updates the supervisor state, and the
//   result lands in the output register, which drives out_valid.
// - Throughput is one item per clock while out_ready is high; the whole
//   decision, with both 16 x 17 bit calibration multiplies, is combinational.
// - When the receiver holds out_ready low, the result stays in the output
//   register and one more item waits in the input register; in_ready then
//   drops until the output register drains.
// - Configuration writes go through cfg_ (3-bit index, 16-bit data);
//   cfg_ready is always high. Write only while no item is in flight.
// - rst_n is synchronous and active low. It empties both stages, restores
//   the register defaults, disables the pulse and marks it stopped.
`default_nettype none

module servo_pulse_stop_supervisor_unit
  import svps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [11:0] in_current_adc,
  input  wire logic [11:0] in_voltage_adc,
  input  wire logic        in_limit0_hit,
  input  wire logic        in_limit1_hit,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_pulse_width,
  output logic             out_pulse_on,
  output logic             out_is_stopped,
  output logic             out_low_supply,
  output logic [15:0]      out_current_ma,
  output logic [15:0]      out_supply_mv,
  output logic [14:0]      out_elapsed_ticks,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic  in_v_r, in_v_nxt;
  logic  out_v_r, out_v_nxt;
  item_t item_r;
  res_t  res_r;
  res_t  res;
  cfg_t  cfg_r;
  logic  adv;

  // The input stage moves forward whenever the output register is free or
  // is being emptied in this cycle.
  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.req_type    <= in_req_type;
      item_r.current_adc <= in_current_adc;
      item_r.voltage_adc <= in_voltage_adc;
      item_r.limit0_hit  <= in_limit0_hit;
      item_r.limit1_hit  <= in_limit1_hit;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  // Configuration register file. Every 3-bit index names a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_current_ma <= RST_STOP_CURRENT;
      cfg_r.stop_timeout    <= RST_STOP_TIMEOUT;
      cfg_r.limit_enables   <= RST_LIMIT_ENABLES;
      cfg_r.pulse_ticks     <= RST_PULSE_TICKS;
      cfg_r.current_gain    <= RST_CURRENT_GAIN;
      cfg_r.current_offset  <= RST_CURRENT_OFFSET;
      cfg_r.voltage_gain    <= RST_VOLTAGE_GAIN;
      cfg_r.voltage_offset  <= RST_VOLTAGE_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STOP_CURRENT:   cfg_r.stop_current_ma <= cfg_data[12:0];
        CFG_STOP_TIMEOUT:   cfg_r.stop_timeout    <= cfg_data[14:0];
        CFG_LIMIT_ENABLES:  cfg_r.limit_enables   <= cfg_data[1:0];
        CFG_PULSE_TICKS:    cfg_r.pulse_ticks     <= cfg_data;
        CFG_CURRENT_GAIN:   cfg_r.current_gain    <= cfg_data;
        CFG_CURRENT_OFFSET: cfg_r.current_offset  <= cfg_data;
        CFG_VOLTAGE_GAIN:   cfg_r.voltage_gain    <= cfg_data;
        CFG_VOLTAGE_OFFSET: cfg_r.voltage_offset  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  svps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_valid         = out_v_r;
  assign out_pulse_width   = res_r.pulse_width;
  assign out_pulse_on      = res_r.pulse_on;
  assign out_is_stopped    = res_r.is_stopped;
  assign out_low_supply    = res_r.low_supply;
  assign out_current_ma    = res_r.current_ma;
  assign out_supply_mv     = res_r.supply_mv;
  assign out_elapsed_ticks = res_r.elapsed_ticks;

  // An item waiting behind a stalled result must stay in the input stage.
  a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && out_v_r && !out_ready) |=> (in_v_r && $stable(item_r)))
    else $error("queued item lost while output stalled");

  // A nonzero pulse width is only reported with the pulse enabled.
  a_width_needs_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (res_r.pulse_width != 16'd0)) |-> res_r.pulse_on)
    else $error("pulse width reported while disabled");

  // Each item that leaves the input stage produces a result next cycle.
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("result register not loaded");

endmodule

`default_nettype wire

### tb/sv/servo_pulse_stop_supervisor_checker.sv
// Result checker for the servo pulse stop supervisor: watches the in_, out_ and cfg_
// channels, keeps its own copy of the supervisor state and registers, and compares results.
// Depends on svps_pkg for the request and register codes and the item and result structs.
module servo_pulse_stop_supervisor_checker
  import svps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [11:0] in_current_adc,
  input  wire logic [11:0] in_voltage_adc,
  input  wire logic        in_limit0_hit,
  input  wire logic        in_limit1_hit,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [15:0] out_pulse_width,
  input  wire logic        out_pulse_on,
  input  wire logic        out_is_stopped,
  input  wire logic        out_low_supply,
  input  wire logic [15:0] out_current_ma,
  input  wire logic [15:0] out_supply_mv,
  input  wire logic [14:0] out_elapsed_ticks,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending_results,
  output int               checked_results
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        regs;
  logic        pulse_enabled;
  logic        stopped;
  logic        go_armed;
  logic        supply_low;
  logic [14:0] elapsed;
  logic [15:0] current_ma;
  logic [15:0] supply_mv;
  res_t        expected_results[$];
  int          problems = 0;
  int          results_seen = 0;

  // Calibration: (gain * (16 * adc - offset)) >> 16, floored at 0 and saturated.
  function automatic logic [15:0] scale_reading(input logic [11:0] adc,
                                                input logic [15:0] gain,
                                                input logic signed [15:0] offset);
    logic [18:0] diff;
    logic [34:0] prod;
    diff = {3'b000, adc, 4'b0000} - {{3{offset[15]}}, offset};
    if (diff[18] || diff == '0) return '0;
    prod = {19'd0, gain} * {17'd0, diff[17:0]};
    if (prod[34:32] != '0) return 16'hFFFF;
    return prod[31:16];
  endfunction

  task automatic supervise_item(input item_t it, output res_t r);
    logic stop_now;
    r.pulse_width = '0;
    case (it.req_type)
      REQ_TICK: begin
        if (pulse_enabled) elapsed = elapsed + 15'd1;
      end
      REQ_UPDATE: begin
        current_ma = scale_reading(it.current_adc, regs.current_gain, regs.current_offset);
        supply_mv  = scale_reading(it.voltage_adc, regs.voltage_gain, regs.voltage_offset);
        supply_low = supply_mv < LOW_SUPPLY_MV;
        stop_now = (regs.limit_enables[0] && it.limit0_hit) ||
                   (regs.limit_enables[1] && it.limit1_hit) ||
                   (regs.stop_current_ma != '0 && elapsed > INRUSH_TICKS &&
                    current_ma > {3'b000, regs.stop_current_ma}) ||
                   (regs.stop_timeout != '0 && elapsed >= regs.stop_timeout);
        stopped = stop_now;
        if (stop_now) pulse_enabled = 1'b0;
        if (go_armed) begin
          if (!stopped) pulse_enabled = 1'b1;
          go_armed = 1'b0;
        end
        if (pulse_enabled) r.pulse_width = regs.pulse_ticks;
      end
      REQ_GO: begin
        pulse_enabled = 1'b0;
        current_ma = '0;
        elapsed = '0;
        go_armed = 1'b1;
      end
      REQ_STOP: begin
        pulse_enabled = 1'b0;
        go_armed = 1'b0;
      end
      REQ_CLEAR: begin
        current_ma = '0;
        elapsed = '0;
      end
      default: ;
    endcase
    r.pulse_on      = pulse_enabled;
    r.is_stopped    = stopped;
    r.low_supply    = supply_low;
    r.current_ma    = current_ma;
    r.supply_mv     = supply_mv;
    r.elapsed_ticks = elapsed;
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      problems++;
      if (problems <= 10)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    item_t it;
    res_t  want;
    res_t  got;
    if (!rst_n) begin
      regs.stop_current_ma = RST_STOP_CURRENT;
      regs.stop_timeout    = RST_STOP_TIMEOUT;
      regs.limit_enables   = RST_LIMIT_ENABLES;
      regs.pulse_ticks     = RST_PULSE_TICKS;
      regs.current_gain    = RST_CURRENT_GAIN;
      regs.current_offset  = RST_CURRENT_OFFSET;
      regs.voltage_gain    = RST_VOLTAGE_GAIN;
      regs.voltage_offset  = RST_VOLTAGE_OFFSET;
      pulse_enabled = 1'b0;
      stopped       = 1'b1;
      go_armed      = 1'b0;
      supply_low    = 1'b0;
      elapsed       = '0;
      current_ma    = '0;
      supply_mv     = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STOP_CURRENT:   regs.stop_current_ma = cfg_data[12:0];
          CFG_STOP_TIMEOUT:   regs.stop_timeout    = cfg_data[14:0];
          CFG_LIMIT_ENABLES:  regs.limit_enables   = cfg_data[1:0];
          CFG_PULSE_TICKS:    regs.pulse_ticks     = cfg_data;
          CFG_CURRENT_GAIN:   regs.current_gain    = cfg_data;
          CFG_CURRENT_OFFSET: regs.current_offset  = cfg_data;
          CFG_VOLTAGE_GAIN:   regs.voltage_gain    = cfg_data;
          CFG_VOLTAGE_OFFSET: regs.voltage_offset  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          problems++;
          if (problems <= 10) $display("[%0t] result item with nothing expected", $time);
        end else begin
          want = expected_results.pop_front();
          got.pulse_width   = out_pulse_width;
          got.pulse_on      = out_pulse_on;
          got.is_stopped    = out_is_stopped;
          got.low_supply    = out_low_supply;
          got.current_ma    = out_current_ma;
          got.supply_mv     = out_supply_mv;
          got.elapsed_ticks = out_elapsed_ticks;
          check_field("pulse_width", want.pulse_width, got.pulse_width);
          check_field("pulse_on", want.pulse_on, got.pulse_on);
          check_field("is_stopped", want.is_stopped, got.is_stopped);
          check_field("low_supply", want.low_supply, got.low_supply);
          check_field("current_ma", want.current_ma, got.current_ma);
          check_field("supply_mv", want.supply_mv, got.supply_mv);
          check_field("elapsed_ticks", want.elapsed_ticks, got.elapsed_ticks);
        end
      end
      if (in_valid && in_ready) begin
        it.req_type    = in_req_type;
        it.current_adc = in_current_adc;
        it.voltage_adc = in_voltage_adc;
        it.limit0_hit  = in_limit0_hit;
        it.limit1_hit  = in_limit1_hit;
        supervise_item(it, want);
        expected_results.push_back(want);
      end
    end
    fail_count      <= problems;
    pending_results <= expected_results.size();
    checked_results <= results_seen;
  end

endmodule

### tb/sv/servo_pulse_stop_supervisor_unit_test.sv
// Top of the servo pulse stop supervisor testbench: clock, reset, item and register
// stimulus, receiver back-pressure and the verdict.
// Depends on svps_pkg, the block under test and servo_pulse_stop_supervisor_checker.
module servo_pulse_stop_supervisor_unit_test
  import svps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Request codes past the clear command; the block must ignore these.
  localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;

  // A correct run sends about a thousand items, each of which may see a sender
  // gap and a receiver stall, plus drains, register writes and one long
  // hold-off. This limit sits above the length of such a run.
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_req_type;
  logic [11:0] in_current_adc;
  logic [11:0] in_voltage_adc;
  logic        in_limit0_hit;
  logic        in_limit1_hit;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_pulse_width;
  logic        out_pulse_on;
  logic        out_is_stopped;
  logic        out_low_supply;
  logic [15:0] out_current_ma;
  logic [15:0] out_supply_mv;
  logic [14:0] out_elapsed_ticks;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending_results;
  int checked_results;

  // Stimulus bookkeeping and the knobs that the main sequence turns.
  int items_sent = 0;
  int settings_used = 0;
  bit sender_idle_on = 1'b1;
  bit receiver_idle_on = 1'b1;
  bit hold_out = 1'b0;

  servo_pulse_stop_supervisor_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_current_adc   (in_current_adc),
    .in_voltage_adc   (in_voltage_adc),
    .in_limit0_hit    (in_limit0_hit),
    .in_limit1_hit    (in_limit1_hit),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pulse_width  (out_pulse_width),
    .out_pulse_on     (out_pulse_on),
    .out_is_stopped   (out_is_stopped),
    .out_low_supply   (out_low_supply),
    .out_current_ma   (out_current_ma),
    .out_supply_mv    (out_supply_mv),
    .out_elapsed_ticks(out_elapsed_ticks),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  servo_pulse_stop_supervisor_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_current_adc   (in_current_adc),
    .in_voltage_adc   (in_voltage_adc),
    .in_limit0_hit    (in_limit0_hit),
    .in_limit1_hit    (in_limit1_hit),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pulse_width  (out_pulse_width),
    .out_pulse_on     (out_pulse_on),
    .out_is_stopped   (out_is_stopped),
    .out_low_supply   (out_low_supply),
    .out_current_ma   (out_current_ma),
    .out_supply_mv    (out_supply_mv),
    .out_elapsed_ticks(out_elapsed_ticks),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending_results  (pending_results),
    .checked_results  (checked_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog. A hung handshake or a lost result ends up here.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("servo_pulse_stop_supervisor_unit test failed");
    $finish;
  end

  // Receiver. It normally accepts, stalls in short random bursts while that is
  // enabled, and on request holds off for a long stretch so that both pipeline
  // stages fill and in_ready drops while the sender keeps offering items.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
        out_ready <= 1'b1;
      end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one item and returns at the clock edge where it is accepted. Signals
  // only change at rising edges, so the ready sampled at the falling edge before
  // is the value that the accepting edge sees. Valid stays high when the next
  // item follows without a gap.
  task automatic offer(input item_t it);
    logic taken;
    if (sender_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= it.req_type;
    in_current_adc <= it.current_adc;
    in_voltage_adc <= it.voltage_adc;
    in_limit0_hit  <= it.limit0_hit;
    in_limit1_hit  <= it.limit1_hit;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Stops offering and waits until every expected result item has come back.
  // Returns on a rising edge so that driving can carry on right away.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    @(posedge clk);
  endtask

  // One register write; cfg_valid stays high between back-to-back writes.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
  endtask

  // Registers are only written with the block idle, so drain first.
  task automatic program_regs(input cfg_t s);
    drain_results();
    write_reg(CFG_STOP_CURRENT, {3'b000, s.stop_current_ma});
    write_reg(CFG_STOP_TIMEOUT, {1'b0, s.stop_timeout});
    write_reg(CFG_LIMIT_ENABLES, {14'd0, s.limit_enables});
    write_reg(CFG_PULSE_TICKS, s.pulse_ticks);
    write_reg(CFG_CURRENT_GAIN, s.current_gain);
    write_reg(CFG_CURRENT_OFFSET, s.current_offset);
    write_reg(CFG_VOLTAGE_GAIN, s.voltage_gain);
    write_reg(CFG_VOLTAGE_OFFSET, s.voltage_offset);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic cfg_t reset_settings();
    cfg_t s;
    s.stop_current_ma = RST_STOP_CURRENT;
    s.stop_timeout    = RST_STOP_TIMEOUT;
    s.limit_enables   = RST_LIMIT_ENABLES;
    s.pulse_ticks     = RST_PULSE_TICKS;
    s.current_gain    = RST_CURRENT_GAIN;
    s.current_offset  = RST_CURRENT_OFFSET;
    s.voltage_gain    = RST_VOLTAGE_GAIN;
    s.voltage_offset  = RST_VOLTAGE_OFFSET;
    return s;
  endfunction

  // A value in [lo, hi] that lands on either end fairly often.
  function automatic int unsigned pick_range(input int unsigned lo, input int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(0, 4);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  // Each gain and offset lies near a working calibration half of the time so that
  // the stop thresholds and the low supply flag are crossed both ways, else anywhere.
  function automatic cfg_t random_settings();
    cfg_t s;
    s.stop_current_ma = 13'(pick_range(0, 5000));
    s.stop_timeout = ($urandom_range(0, 3) == 0) ? 15'(pick_range(0, 30000))
                                                 : 15'($urandom_range(0, 120));
    s.limit_enables  = 2'($urandom_range(0, 3));
    s.pulse_ticks    = 16'(pick_range(0, 65535));
    s.current_gain   = $urandom_range(0, 1) ? 16'(pick_range(0, 65535))
                                            : 16'($urandom_range(2000, 6000));
    s.current_offset = $urandom_range(0, 1) ? 16'(pick_range(0, 65535))
                                            : 16'($urandom_range(0, 3000));
    s.voltage_gain   = $urandom_range(0, 1) ? 16'(pick_range(0, 65535))
                                            : 16'($urandom_range(8000, 14000));
    s.voltage_offset = $urandom_range(0, 1) ? 16'(pick_range(0, 65535))
                                            : 16'($urandom_range(8000, 20000));
    return s;
  endfunction

  function automatic item_t item_of(input logic [2:0] req, input logic [11:0] cur,
                                    input logic [11:0] volt, input logic l0,
                                    input logic l1);
    item_t it;
    it.req_type    = req;
    it.current_adc = cur;
    it.voltage_adc = volt;
    it.limit0_hit  = l0;
    it.limit1_hit  = l1;
    return it;
  endfunction

  function automatic logic [11:0] random_adc();
    return 12'(pick_range(0, 4095));
  endfunction

  // Mostly ticks and updates, with enough go commands that the pulse gets
  // enabled often and long runs of ticks carry the count past the inrush
  // window and small timeouts. Stop, clear and reserved codes are the noise.
  function automatic item_t random_item();
    int unsigned roll;
    logic [2:0] req;
    roll = $urandom_range(0, 99);
    if (roll < 40)      req = REQ_TICK;
    else if (roll < 75) req = REQ_UPDATE;
    else if (roll < 83) req = REQ_GO;
    else if (roll < 88) req = REQ_STOP;
    else if (roll < 94) req = REQ_CLEAR;
    else                req = 3'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
    return item_of(req, random_adc(), random_adc(), $urandom_range(0, 5) == 0,
                   $urandom_range(0, 5) == 0);
  endfunction

  initial begin
    cfg_t s;
    in_valid       <= 1'b0;
    in_req_type    <= REQ_TICK;
    in_current_adc <= '0;
    in_voltage_adc <= '0;
    in_limit0_hit  <= 1'b0;
    in_limit1_hit  <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_STOP_CURRENT;
    cfg_data       <= '0;
    rst_n          <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Straight out of reset with the default registers: reserved codes, a tick
    // while disabled, an update with the limits not enabled, then go, an update,
    // ticks, clear, stop and a final update.
    offer(item_of(REQ_RESERVED_FIRST, 12'hFFF, 12'hFFF, 1'b1, 1'b1));
    offer(item_of(REQ_RESERVED_LAST, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_TICK, 12'hABC, 12'h543, 1'b1, 1'b0));
    offer(item_of(REQ_UPDATE, 12'h000, 12'h000, 1'b1, 1'b1));
    offer(item_of(REQ_GO, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_UPDATE, 12'hFFF, 12'hFFF, 1'b0, 1'b0));
    offer(item_of(REQ_TICK, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_TICK, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_CLEAR, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_STOP, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_UPDATE, 12'h800, 12'h800, 1'b0, 1'b0));

    // Inrush window: the overcurrent stop must not fire at 20 elapsed ticks and
    // must fire at 21. A zero pulse width gives a width of 0 even while enabled.
    // Then each limit switch on its own.
    s = reset_settings();
    s.stop_current_ma = 13'd100;
    s.limit_enables   = 2'b11;
    s.pulse_ticks     = 16'd0;
    program_regs(s);
    offer(item_of(REQ_GO, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_UPDATE, 12'hFFF, 12'hFFF, 1'b0, 1'b0));
    repeat (20) offer(item_of(REQ_TICK, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_UPDATE, 12'hFFF, 12'hFFF, 1'b0, 1'b0));
    offer(item_of(REQ_TICK, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_UPDATE, 12'hFFF, 12'hFFF, 1'b0, 1'b0));
    offer(item_of(REQ_GO, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_UPDATE, 12'h000, 12'h000, 1'b0, 1'b1));
    offer(item_of(REQ_GO, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_UPDATE, 12'h000, 12'hFFF, 1'b1, 1'b0));

    // The shortest timeout: once enabled, one tick is enough to stop.
    s = reset_settings();
    s.stop_timeout = 15'd1;
    program_regs(s);
    offer(item_of(REQ_GO, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_UPDATE, 12'h123, 12'hC00, 1'b0, 1'b0));
    offer(item_of(REQ_TICK, 12'h000, 12'h000, 1'b0, 1'b0));
    offer(item_of(REQ_UPDATE, 12'h123, 12'hC00, 1'b0, 1'b0));

    // Every register at its low end: gains of zero read nothing, offsets at
    // the most negative value.
    s.stop_current_ma = 13'd0;
    s.stop_timeout    = 15'd0;
    s.limit_enables   = 2'b00;
    s.pulse_ticks     = 16'd0;
    s.current_gain    = 16'd0;
    s.current_offset  = 16'sh8000;
    s.voltage_gain    = 16'd0;
    s.voltage_offset  = 16'sh8000;
    program_regs(s);
    repeat (100) offer(random_item());

    // Gains, offsets, pulse ticks and limit enables at maximum; no reading saturates.
    s.stop_current_ma = 13'd5000;
    s.stop_timeout    = 15'd30000;
    s.limit_enables   = 2'b11;
    s.pulse_ticks     = 16'hFFFF;
    s.current_gain    = 16'hFFFF;
    s.current_offset  = 16'sh7FFF;
    s.voltage_gain    = 16'hFFFF;
    s.voltage_offset  = 16'sh7FFF;
    program_regs(s);
    repeat (100) offer(random_item());

    // Random settings. In the second one the receiver holds off while the sender
    // keeps offering, so the block backs up and stalls its input. The last one
    // runs with no idling on either side.
    for (int p = 0; p < 5; p++) begin
      if (p == 4) begin
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
      end
      program_regs(random_settings());
      if (p == 1) begin
        hold_out = 1'b1;
        sender_idle_on = 1'b0;
        repeat (16) offer(random_item());
        sender_idle_on = 1'b1;
      end
      repeat (140) offer(random_item());
    end

    drain_results();
    // Give any stray result time to show.
    repeat (4) @(posedge clk);

    $display("Run covered %0d items over %0d register settings, reserved codes,",
             items_sent, settings_used);
    $display("the inrush boundary and a %0d-cycle receiver hold-off; %0d results compared.",
             HOLD_CYCLES, checked_results);
    if (fail_count == 0 && pending_results == 0)
      $display("servo_pulse_stop_supervisor_unit test passed");
    else
      $display("servo_pulse_stop_supervisor_unit test failed");
    $finish;
  end

endmodule
